/* rtl/idmt_pkg.sv */
package idmt_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int WORD_W      = 64;
    localparam int KEY_W       = 6 * WORD_W;
    localparam int DIGEST_W    = 4 * WORD_W;
    localparam int STAMP_W     = WORD_W;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] source_tag;
        logic [63:0] file_length;
        logic [63:0] vol_serial;
        logic [63:0] file_id_low;
        logic [63:0] file_id_high;
        logic [63:0] write_time;
        logic [63:0] digest_in_w0;
        logic [63:0] digest_in_w1;
        logic [63:0] digest_in_w2;
        logic [63:0] digest_in_w3;
        logic [63:0] now_ms;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] digest_out_w0;
        logic [63:0] digest_out_w1;
        logic [63:0] digest_out_w2;
        logic [63:0] digest_out_w3;
        logic        evicted;
        logic [5:0]  slot_index;
        logic [6:0]  occupied_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ_DIGEST,
        ST_COMMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic digest_rd;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit_now;
        logic scan_done;
        logic res_free;
        logic is_lookup;
    } sts_t;

    function automatic logic [KEY_W-1:0] key_of(input req_t r);
        key_of = {r.write_time, r.file_id_high, r.file_id_low,
                  r.vol_serial, r.file_length, r.source_tag};
    endfunction

    function automatic logic [DIGEST_W-1:0] digest_of(input req_t r);
        digest_of = {r.digest_in_w3, r.digest_in_w2, r.digest_in_w1, r.digest_in_w0};
    endfunction

endpackage

/* rtl/idmt_req_if.sv */
interface idmt_req_if;
    logic           valid;
    logic           ready;
    idmt_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/idmt_rsp_if.sv */
interface idmt_rsp_if;
    logic           valid;
    logic           ready;
    idmt_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/idmt_ram.sv */
module idmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/idmt_ctrl.sv */
module idmt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  idmt_pkg::sts_t     sts,
    output idmt_pkg::cmd_t     cmd
);

    idmt_pkg::state_t state_reg;
    idmt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idmt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idmt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = idmt_pkg::ST_SCAN;
                end
            end
            idmt_pkg::ST_SCAN:
            begin
                if (sts.hit_now)
                begin
                    state_next = sts.is_lookup ? idmt_pkg::ST_READ_DIGEST
                                               : idmt_pkg::ST_COMMIT;
                end
                else if (sts.scan_done)
                begin
                    state_next = idmt_pkg::ST_COMMIT;
                end
            end
            idmt_pkg::ST_READ_DIGEST:
            begin
                state_next = idmt_pkg::ST_COMMIT;
            end
            idmt_pkg::ST_COMMIT:
            begin
                if (sts.res_free)
                begin
                    state_next = idmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = idmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        case (state_reg)
            idmt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
            end
            idmt_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            idmt_pkg::ST_READ_DIGEST:
            begin
                cmd.digest_rd = 1'b1;
            end
            idmt_pkg::ST_COMMIT:
            begin
                cmd.commit = sts.res_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/idmt_dp.sv */
module idmt_dp #(
    parameter int ENTRIES = idmt_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  idmt_pkg::req_t req_data,
    output idmt_pkg::rsp_t rsp_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  idmt_pkg::cmd_t cmd,
    output idmt_pkg::sts_t sts
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    idmt_pkg::req_t item_reg;
    idmt_pkg::rsp_t res_reg;
    idmt_pkg::rsp_t res_next;
    logic           res_valid_reg;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] issue_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             match_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [idmt_pkg::STAMP_W-1:0] min_reg;
    logic [IDX_W-1:0] oldest_reg;

    logic [idmt_pkg::KEY_W-1:0]    key_rd;
    logic [idmt_pkg::STAMP_W-1:0]  stamp_rd;
    logic [idmt_pkg::DIGEST_W-1:0] digest_rd;

    logic             key_eq;
    logic             issue_go;
    logic             full;
    logic             is_insert;
    logic [IDX_W-1:0] target;
    logic             wr_key;
    logic             wr_data;
    logic [31:0]      target_wide;
    logic [31:0]      match_wide;
    logic [31:0]      fill_wide;

    assign key_eq    = key_rd == idmt_pkg::key_of(item_reg);
    assign issue_go  = cmd.scan && (issue_reg < fill_reg);
    assign full      = fill_reg == CNT_W'(ENTRIES);
    assign is_insert = item_reg.req_type == idmt_pkg::REQ_INSERT;

    // occupied slots always form a prefix, so the fill count is the free slot
    assign target  = match_reg ? match_idx_reg : (full ? oldest_reg : fill_reg[IDX_W-1:0]);
    assign wr_data = cmd.commit && is_insert;
    assign wr_key  = wr_data && !match_reg;

    assign fill_next = (wr_key && !full) ? fill_reg + CNT_W'(1) : fill_reg;

    assign target_wide = 32'(target);
    assign match_wide  = 32'(match_idx_reg);
    assign fill_wide   = 32'(fill_next);

    assign sts.hit_now   = pend_reg && key_eq;
    assign sts.scan_done = !pend_reg && (issue_reg >= fill_reg);
    assign sts.res_free  = !res_valid_reg || rsp_ready;
    assign sts.is_lookup = !is_insert;

    idmt_ram #(.WIDTH(idmt_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_key),
        .wr_addr (target),
        .wr_data (idmt_pkg::key_of(item_reg)),
        .rd_en   (issue_go),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (key_rd)
    );

    idmt_ram #(.WIDTH(idmt_pkg::STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .clk     (clk),
        .wr_en   (wr_data),
        .wr_addr (target),
        .wr_data (item_reg.now_ms),
        .rd_en   (issue_go),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (stamp_rd)
    );

    idmt_ram #(.WIDTH(idmt_pkg::DIGEST_W), .DEPTH(ENTRIES)) u_digest_ram (
        .clk     (clk),
        .wr_en   (wr_data),
        .wr_addr (target),
        .wr_data (idmt_pkg::digest_of(item_reg)),
        .rd_en   (cmd.digest_rd),
        .rd_addr (match_idx_reg),
        .rd_data (digest_rd)
    );

    always_comb
    begin
        res_next                = '0;
        res_next.occupied_count = fill_wide[6:0];
        if (is_insert)
        begin
            res_next.hit        = match_reg;
            res_next.evicted    = !match_reg && full;
            res_next.slot_index = target_wide[5:0];
        end
        else if (match_reg)
        begin
            res_next.hit           = 1'b1;
            res_next.slot_index    = match_wide[5:0];
            res_next.digest_out_w0 = digest_rd[63:0];
            res_next.digest_out_w1 = digest_rd[127:64];
            res_next.digest_out_w2 = digest_rd[191:128];
            res_next.digest_out_w3 = digest_rd[255:192];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            match_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.start)
            begin
                issue_reg <= '0;
                pend_reg  <= 1'b0;
                match_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= issue_go;
                if (issue_go)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (pend_reg && key_eq)
                begin
                    match_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            item_reg   <= req_data;
            min_reg    <= '1;
            oldest_reg <= '0;
        end
        else if (cmd.scan)
        begin
            pend_idx_reg <= issue_reg[IDX_W-1:0];
            if (pend_reg && key_eq)
            begin
                match_idx_reg <= pend_idx_reg;
            end
            else if (pend_reg && (stamp_rd < min_reg))
            begin
                // strictly smaller only, so ties keep the lower slot
                min_reg    <= stamp_rd;
                oldest_reg <= pend_idx_reg;
            end
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp_data  = res_reg;
    assign rsp_valid = res_valid_reg;

endmodule

/* rtl/identity_digest_memo_table_unit.sv */
// Fully associative memo of ENTRIES slots keyed by file identity (source tag, length,
// volume serial, 128-bit file id, write time) holding a 256-bit digest and an insert
// stamp. One word is worked at a time: the occupied slots are scanned one per cycle
// through the read port of the key and stamp memories. A miss scans every occupied
// slot; a hit ends the scan at the matching slot, and a lookup that hits then reads
// the digest memory in a state of its own before the result is committed. Inserts
// fill the lowest free slot, then replace the slot with the strictly smallest stamp.
// The table is empty straight after reset with no clearing pass. A finished result
// sits in an output register while the next word is taken and scanned.
module identity_digest_memo_table_unit #(
    parameter int ENTRIES = idmt_pkg::ENTRIES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    idmt_req_if.sink   req,
    idmt_rsp_if.source rsp
);

    idmt_pkg::cmd_t cmd;
    idmt_pkg::sts_t sts;

    idmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    idmt_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .rsp_data  (rsp.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* tb/sv/tb_identity_digest_memo_table_unit.sv */
`timescale 1ns / 1ps

module tb_identity_digest_memo_table_unit;
    import idmt_pkg::*;

    localparam int ENTRIES    = ENTRIES_DEF;
    localparam int POOL_SIZE  = 96;
    localparam int PHASE_LEN  = 275;
    localparam int CYCLE_CAP  = 1000000;

    typedef bit [63:0] word_t;
    typedef word_t ident_t [6];
    typedef word_t digest_t [4];

    typedef struct {
        req_t word;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    idmt_req_if req_ch ();
    idmt_rsp_if rsp_ch ();

    identity_digest_memo_table_unit #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // shadow copy of the memo table
    bit      slot_used   [ENTRIES];
    ident_t  slot_id     [ENTRIES];
    digest_t slot_digest [ENTRIES];
    word_t   slot_stamp  [ENTRIES];

    rsp_t     pending_results [$];
    dir_row_t dir_rows [$];
    ident_t   ident_pool [POOL_SIZE];

    int    send_idle_pct;
    int    sink_stall_pct;
    int    mismatch_count;
    int    cycle_count;
    word_t mono_ms;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("tb_identity_digest_memo_table_unit: done, errors");
            $finish;
        end
    end

    function automatic bit same_ident(input ident_t a, input ident_t b);
        bit eq;
        eq = 1'b1;
        for (int i = 0; i < 6; i++)
            if (a[i] != b[i])
                eq = 1'b0;
        return eq;
    endfunction

    function automatic rsp_t memo_predict(input req_t w);
        rsp_t        r;
        ident_t      id;
        digest_t     dg;
        int          match_slot;
        int          first_free;
        int          stale_slot;
        int          target;
        word_t       oldest;
        int unsigned used;
        r  = '0;
        id = '{w.source_tag, w.file_length, w.vol_serial,
               w.file_id_low, w.file_id_high, w.write_time};
        dg = '{w.digest_in_w0, w.digest_in_w1, w.digest_in_w2, w.digest_in_w3};
        match_slot = -1;
        first_free = -1;
        stale_slot = 0;
        oldest     = '1;
        for (int s = 0; s < ENTRIES; s++)
        begin
            if (!slot_used[s])
            begin
                if (first_free < 0)
                    first_free = s;
            end
            else
            begin
                if (match_slot < 0 && same_ident(slot_id[s], id))
                    match_slot = s;
                // strictly smaller only, so ties keep the lowest index
                if (slot_stamp[s] < oldest)
                begin
                    oldest     = slot_stamp[s];
                    stale_slot = s;
                end
            end
        end
        if (match_slot >= 0)
        begin
            r.hit        = 1'b1;
            r.slot_index = 6'(match_slot);
            if (w.req_type == REQ_LOOKUP)
            begin
                r.digest_out_w0 = slot_digest[match_slot][0];
                r.digest_out_w1 = slot_digest[match_slot][1];
                r.digest_out_w2 = slot_digest[match_slot][2];
                r.digest_out_w3 = slot_digest[match_slot][3];
            end
            else
            begin
                slot_digest[match_slot] = dg;
                slot_stamp[match_slot]  = w.now_ms;
            end
        end
        else if (w.req_type == REQ_INSERT)
        begin
            target              = (first_free >= 0) ? first_free : stale_slot;
            r.evicted           = (first_free < 0);
            r.slot_index        = 6'(target);
            slot_used[target]   = 1'b1;
            slot_id[target]     = id;
            slot_digest[target] = dg;
            slot_stamp[target]  = w.now_ms;
        end
        used = 0;
        for (int s = 0; s < ENTRIES; s++)
            used += slot_used[s];
        r.occupied_count = 7'(used);
        return r;
    endfunction

    function automatic word_t rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        else if (pick < 16)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic ident_t rand_ident();
        ident_t id;
        for (int i = 0; i < 6; i++)
            id[i] = rand_word();
        return id;
    endfunction

    function automatic digest_t rand_digest();
        digest_t dg;
        for (int i = 0; i < 4; i++)
            dg[i] = rand_word();
        return dg;
    endfunction

    function automatic req_t make_word(input logic kind, input ident_t id,
                                       input digest_t dg, input word_t stamp);
        req_t w;
        w.req_type      = kind;
        w.source_tag    = id[0];
        w.file_length   = id[1];
        w.vol_serial    = id[2];
        w.file_id_low   = id[3];
        w.file_id_high  = id[4];
        w.write_time    = id[5];
        w.digest_in_w0  = dg[0];
        w.digest_in_w1  = dg[1];
        w.digest_in_w2  = dg[2];
        w.digest_in_w3  = dg[3];
        w.now_ms        = stamp;
        return w;
    endfunction

    function automatic rsp_t plain_rsp(input bit hit, input bit ev,
                                       input int slot, input int count);
        rsp_t r;
        r                = '0;
        r.hit            = hit;
        r.evicted        = ev;
        r.slot_index     = 6'(slot);
        r.occupied_count = 7'(count);
        return r;
    endfunction

    task automatic add_row(input req_t w, input bit typed, input rsp_t want);
        dir_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic push_word(input req_t w, input bit typed, input rsp_t want);
        rsp_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        pred = memo_predict(w);
        pending_results.insert(pending_results.size(), typed ? want : pred);
    endtask

    task automatic push_random_word();
        ident_t  id;
        word_t   stamp;
        int      pick;
        rsp_t    none;
        none = '0;
        // mostly known identities so lookups hit and inserts refresh
        if ($urandom_range(99) < 10)
            id = rand_ident();
        else
            id = ident_pool[$urandom_range(POOL_SIZE - 1)];
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            mono_ms += $urandom_range(50, 1);
            stamp = mono_ms;
        end
        else if (pick < 80)
            stamp = $urandom_range(3);
        else if (pick < 92)
            stamp = {$urandom, $urandom};
        else
            stamp = '1;
        push_word(make_word($urandom_range(1) ? REQ_INSERT : REQ_LOOKUP, id,
                            rand_digest(), stamp), 1'b0, none);
    endtask

    // fresh identities with the all-ones stamp: once every slot holds it,
    // nothing is strictly older and slot 0 is the one replaced
    task automatic push_stamp_sweep();
        rsp_t none;
        none = '0;
        for (int i = 0; i < ENTRIES + 2; i++)
            push_word(make_word(REQ_INSERT, rand_ident(), rand_digest(), '1), 1'b0, none);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t %s: expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected word: expected none got %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, got.hit);
                check_field("digest_out_w0", want.digest_out_w0, got.digest_out_w0);
                check_field("digest_out_w1", want.digest_out_w1, got.digest_out_w1);
                check_field("digest_out_w2", want.digest_out_w2, got.digest_out_w2);
                check_field("digest_out_w3", want.digest_out_w3, got.digest_out_w3);
                check_field("evicted", want.evicted, got.evicted);
                check_field("slot_index", want.slot_index, got.slot_index);
                check_field("occupied_count", want.occupied_count, got.occupied_count);
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial
    begin
        ident_t  k0;
        ident_t  k1;
        ident_t  kx;
        digest_t d_ones;
        digest_t d_pat;
        digest_t d_alt;
        digest_t d_zero;
        rsp_t    none;
        int      idle_plan  [4];
        int      stall_plan [4];
        int      n;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        mono_ms        = 64'd1000;
        none           = '0;
        idle_plan      = '{0, 59, 0, 34};
        stall_plan     = '{0, 0, 59, 34};

        for (int i = 0; i < POOL_SIZE / 2; i++)
            ident_pool[i] = rand_ident();
        // second half differs from the first in a single field
        for (int i = POOL_SIZE / 2; i < POOL_SIZE; i++)
        begin
            ident_pool[i] = ident_pool[i - POOL_SIZE / 2];
            ident_pool[i][$urandom_range(5)] = {$urandom, $urandom};
        end

        k0     = '{6{64'h0}};
        k1     = '{6{64'hffff_ffff_ffff_ffff}};
        d_zero = '{4{64'h0}};
        d_ones = '{4{64'hffff_ffff_ffff_ffff}};
        d_pat  = '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                   64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555};
        d_alt  = '{64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe,
                   64'hdead_beef_cafe_f00d, 64'h0f0f_0f0f_f0f0_f0f0};

        add_row(make_word(REQ_LOOKUP, k0, d_zero, 64'h0), 1'b1, plain_rsp(0, 0, 0, 0));
        add_row(make_word(REQ_INSERT, k0, d_ones, 64'h0), 1'b1, plain_rsp(0, 0, 0, 1));
        add_row(make_word(REQ_INSERT, k1, d_pat, '1), 1'b1, plain_rsp(0, 0, 1, 2));
        add_row(make_word(REQ_LOOKUP, k0, d_zero, 64'h0), 1'b0, none);
        add_row(make_word(REQ_LOOKUP, k1, d_zero, 64'h0), 1'b0, none);
        // near misses: one key field cleared at a time
        for (int f = 0; f < 6; f++)
        begin
            kx    = k1;
            kx[f] = 64'h0;
            add_row(make_word(REQ_LOOKUP, kx, d_ones, '1), 1'b1, plain_rsp(0, 0, 0, 2));
        end
        add_row(make_word(REQ_INSERT, k0, d_alt, 64'd5), 1'b1, plain_rsp(1, 0, 0, 2));
        add_row(make_word(REQ_LOOKUP, k0, d_ones, '1), 1'b0, none);
        kx    = k1;
        kx[5] = 64'h0;
        add_row(make_word(REQ_INSERT, kx, d_zero, 64'd7), 1'b1, plain_rsp(0, 0, 2, 3));
        add_row(make_word(REQ_LOOKUP, kx, d_pat, '1), 1'b0, none);
        add_row(make_word(REQ_LOOKUP, k1, d_alt, 64'd9), 1'b0, none);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_plan[ph];
            sink_stall_pct = stall_plan[ph];
            n = 0;
            while (n < PHASE_LEN)
            begin
                if ((ph == 1 || ph == 3) && n == 100)
                begin
                    push_stamp_sweep();
                    n += ENTRIES + 2;
                end
                else
                begin
                    push_random_word();
                    n++;
                end
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 10) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0)
            $display("tb_identity_digest_memo_table_unit: done, clean");
        else
            $display("tb_identity_digest_memo_table_unit: done, errors");
        $finish;
    end

endmodule
